### design/rrbm_pkg.sv
// Shared types and constants for the ROM/RAM bank mapper.
// Used by rrbm_rem_unit and rom_ram_bank_mapper_core; no dependencies.
package rrbm_pkg;

    // Bit-serial remainder unit sizes
    localparam int REM_DVD_W = 9;   // widest bank value reduced
    localparam int REM_DSR_W = 10;  // widest bank count
    localparam int REM_CNT_W = $clog2(REM_DVD_W);

    localparam int ROM_BANK_W  = 9;
    localparam int RAM_BANK_W  = 4;
    localparam int ROM_CNT_W   = 10;
    localparam int RAM_CNT_W   = 5;
    localparam int MAP_ADDR_W  = 23;
    localparam int ROM_OFS_W   = 14;   // 16 KiB bank
    localparam int RAM_OFS_W   = 13;   // 8 KiB bank

    // Result target codes
    localparam logic [1:0] TGT_ROM   = 2'd0;
    localparam logic [1:0] TGT_RAM   = 2'd1;
    localparam logic [1:0] TGT_OPEN  = 2'd2;
    localparam logic [1:0] TGT_WRITE = 2'd3;

    // Register select (paddr[2])
    localparam logic REG_ROM_COUNT = 1'b0;
    localparam logic REG_RAM_COUNT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REM,
        ST_DONE
    } t_state;

endpackage

### design/rom_ram_bank_mapper_core.sv
// Top level of the ROM/RAM bank mapper: sequencer, bank state, APB registers.
// Depends on rrbm_pkg and rrbm_rem_unit.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------
//  in      | in        | i_in_valid / o_in_ready    | i_action, i_bus_addr, i_write_data
//  out     | out       | o_out_valid / i_out_ready  | o_target, o_mapped_addr
//  cfg     | in        | psel, penable, pwrite      | paddr, pwdata, prdata, pready
//
// A read, or a write outside the bank registers, goes from IDLE to DONE and back.
// A bank write (0x2000-0x5FFF) waits in REM in between: the remainder by the
// bank count goes through the bit-serial unit, one dividend bit per cycle.
// Reset is synchronous, active low, and restores the counts and bank state.
// A result waiting at the output does not block the next transfer; only the
// commit of the following result waits until the output register is free.
module rom_ram_bank_mapper_core
    import rrbm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_action,
    input  logic [15:0]           i_bus_addr,
    input  logic [7:0]            i_write_data,
    // output channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_target,
    output logic [MAP_ADDR_W-1:0] o_mapped_addr,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    // ---------------------------------------------------------------------
    // State
    // ---------------------------------------------------------------------
    t_state r_state, n_state;

    logic                  r_action;
    logic [15:0]           r_addr;
    logic [7:0]            r_wdata;

    logic                  r_ram_on;
    logic [ROM_BANK_W-1:0] r_rom_bank;
    logic [RAM_BANK_W-1:0] r_ram_bank;
    logic [ROM_CNT_W-1:0]  r_rom_count;
    logic [RAM_CNT_W-1:0]  r_ram_count;

    logic                  r_out_valid;
    logic [1:0]            r_target;
    logic [MAP_ADDR_W-1:0] r_mapped;

    logic                  w_rem_start;
    logic                  w_rem_done;
    logic [REM_DVD_W-1:0]  w_dividend;
    logic [REM_DSR_W-1:0]  w_divisor;
    logic [REM_DSR_W-1:0]  w_rem_val;

    logic                  w_in_xfer;
    logic                  w_bank_wr;   // incoming transfer needs the remainder unit
    logic                  w_commit;
    logic                  w_cfg_wr;

    logic [1:0]            n_target;
    logic [MAP_ADDR_W-1:0] n_mapped;

    assign w_in_xfer = i_in_valid && o_in_ready;
    assign w_commit  = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    // ---------------------------------------------------------------------
    // Operand select for the remainder unit, straight from the input item
    // ---------------------------------------------------------------------
    always_comb begin
        w_bank_wr  = 1'b0;
        w_dividend = '0;
        w_divisor  = REM_DSR_W'(r_rom_count);
        if (i_action) begin
            unique case (i_bus_addr[15:12])
                4'h2: begin
                    w_bank_wr  = 1'b1;
                    w_dividend = {r_rom_bank[8], i_write_data};
                end
                4'h3: begin
                    w_bank_wr  = 1'b1;
                    w_dividend = {i_write_data[0], r_rom_bank[7:0]};
                end
                4'h4, 4'h5: begin
                    w_bank_wr  = 1'b1;
                    w_dividend = {1'b0, i_write_data};
                    w_divisor  = REM_DSR_W'(r_ram_count);
                end
                default: begin
                    w_bank_wr = 1'b0;
                end
            endcase
        end
    end

    rrbm_rem_unit u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_rem_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_rem_done),
        .o_rem      (w_rem_val)
    );

    // ---------------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    n_state = w_bank_wr ? ST_REM : ST_DONE;
                end
            end
            ST_REM: begin
                if (w_rem_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_commit) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sequencer: outputs
    always_comb begin
        o_in_ready  = 1'b0;
        w_rem_start = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                w_rem_start = i_in_valid && w_bank_wr;
            end
            ST_REM, ST_DONE: begin
                o_in_ready = 1'b0;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // latched item
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_action <= i_action;
            r_addr   <= i_bus_addr;
            r_wdata  <= i_write_data;
        end
    end

    // ---------------------------------------------------------------------
    // Result of the latched item
    // ---------------------------------------------------------------------
    always_comb begin
        n_target = TGT_OPEN;
        n_mapped = '0;
        if (r_action) begin
            n_target = TGT_WRITE;
        end else begin
            unique case (r_addr[15:12])
                4'h0, 4'h1, 4'h2, 4'h3: begin
                    n_target = TGT_ROM;
                    n_mapped = MAP_ADDR_W'(r_addr);
                end
                4'h4, 4'h5, 4'h6, 4'h7: begin
                    n_target = TGT_ROM;
                    n_mapped = {r_rom_bank, r_addr[ROM_OFS_W-1:0]};
                end
                4'hA, 4'hB: begin
                    if (r_ram_on) begin
                        n_target = TGT_RAM;
                        n_mapped = MAP_ADDR_W'({r_ram_bank, r_addr[RAM_OFS_W-1:0]});
                    end
                end
                default: begin
                    n_target = TGT_OPEN;
                end
            endcase
        end
    end

    // bank state, committed with the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ram_on   <= 1'b0;
            r_rom_bank <= ROM_BANK_W'(1);
            r_ram_bank <= '0;
        end else if (w_commit && r_action) begin
            unique case (r_addr[15:12])
                4'h0, 4'h1: begin
                    r_ram_on <= (r_wdata[3:0] == 4'hA);
                end
                4'h2, 4'h3: begin
                    // count of zero forces bank zero; above 512 leaves it as is
                    r_rom_bank <= (r_rom_count == '0) ? '0 : w_rem_val[ROM_BANK_W-1:0];
                end
                4'h4, 4'h5: begin
                    r_ram_bank <= (r_ram_count == '0) ? '0 : w_rem_val[RAM_BANK_W-1:0];
                end
                default: begin
                    r_ram_on <= r_ram_on;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_target <= n_target;
            r_mapped <= n_mapped;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_target      = r_target;
    assign o_mapped_addr = r_mapped;

    // ---------------------------------------------------------------------
    // Configuration registers: bank counts, decoded on paddr[2]
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_count <= ROM_CNT_W'(512);
            r_ram_count <= RAM_CNT_W'(16);
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                REG_ROM_COUNT: r_rom_count <= pwdata[ROM_CNT_W-1:0];
                REG_RAM_COUNT: r_ram_count <= pwdata[RAM_CNT_W-1:0];
                default:       r_rom_count <= r_rom_count;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_ROM_COUNT: prdata = 32'(r_rom_count);
            REG_RAM_COUNT: prdata = 32'(r_ram_count);
            default:       prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    // remainder only completes while the sequencer waits for it
    a_rem_done_in_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rem_done |-> (r_state == ST_REM))
        else $error("remainder done outside wait state");

    // a new result appears only after a commit
    a_out_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_commit))
        else $error("output valid without commit");

    // a transfer always moves the sequencer out of idle
    a_xfer_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state != ST_IDLE))
        else $error("sequencer stayed idle after transfer");

    // a RAM bank write leaves the bank below a nonzero count in range
    a_ram_bank_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && r_action && (r_addr[15:13] == 3'b010) && (r_ram_count != '0)
            && (r_ram_count <= RAM_CNT_W'(16)))
        |=> ({1'b0, r_ram_bank} < $past(r_ram_count)))
        else $error("RAM bank not reduced by count");

endmodule

### design/rrbm_rem_unit.sv
// Bit-serial restoring remainder: one dividend bit per cycle.
// Depends on rrbm_pkg.
module rrbm_rem_unit
    import rrbm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [REM_DVD_W-1:0] i_dividend,
    input  logic [REM_DSR_W-1:0] i_divisor,
    output logic                 o_done,
    output logic [REM_DSR_W-1:0] o_rem
);

    localparam logic [REM_CNT_W-1:0] LAST_STEP = REM_CNT_W'(REM_DVD_W - 1);

    logic                 r_busy;
    logic                 r_done;
    logic [REM_CNT_W-1:0] r_cnt;
    logic [REM_DVD_W-1:0] r_dvd;
    logic [REM_DSR_W-1:0] r_dsr;
    logic [REM_DSR_W-1:0] r_rem;

    logic [REM_DSR_W:0]   w_trial;
    logic [REM_DSR_W:0]   w_diff;
    logic [REM_DSR_W-1:0] n_rem;

    // shift in next bit, subtract when it fits
    always_comb begin
        w_trial = {r_rem, r_dvd[REM_DVD_W-1]};
        w_diff  = w_trial - {1'b0, r_dsr};
        if (w_trial >= {1'b0, r_dsr}) begin
            n_rem = w_diff[REM_DSR_W-1:0];
        end else begin
            n_rem = w_trial[REM_DSR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[REM_DVD_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for rom_ram_bank_mapper_core: bus accesses in, mapped targets out.
// Depends on rrbm_pkg and the core RTL; holds its own model of the bank state.
module tb_top;
    import rrbm_pkg::*;

    localparam int unsigned LIMIT_NS = 3_000_000;

    // One bus access as it sits on the input channel
    typedef struct packed {
        logic        action;
        logic [15:0] addr;
        logic [7:0]  data;
    } bus_access_t;

    // One translated access as it leaves the output channel
    typedef struct packed {
        logic [1:0]            target;
        logic [MAP_ADDR_W-1:0] maddr;
    } bank_map_t;

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports (every input known from time zero)
    // ------------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_action = 1'b0;
    logic [15:0]           i_bus_addr = '0;
    logic [7:0]            i_write_data = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [1:0]            o_target;
    logic [MAP_ADDR_W-1:0] o_mapped_addr;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [2:0]            paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    rom_ram_bank_mapper_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_action      (i_action),
        .i_bus_addr    (i_bus_addr),
        .i_write_data  (i_write_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_target      (o_target),
        .o_mapped_addr (o_mapped_addr),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Mapper model: bank counts as last written, bank state as it should
    // stand after every accepted access
    // ------------------------------------------------------------------
    logic [ROM_CNT_W-1:0]  rom_cnt = 10'd512;
    logic [RAM_CNT_W-1:0]  ram_cnt = 5'd16;
    logic                  ram_on = 1'b0;
    logic [ROM_BANK_W-1:0] rom_bank = 9'd1;
    logic [RAM_BANK_W-1:0] ram_bank = '0;

    bus_access_t pending_accesses[$];
    bank_map_t   expected_maps[$];

    int unsigned err_cnt = 0;
    int unsigned n_reads = 0;
    int unsigned n_writes = 0;
    int unsigned n_settings = 0;
    logic        quiet = 1'b0;     // no idling on either side while set
    logic        in_xfer = 1'b0;   // input transfer seen at the last rising edge
    int unsigned send_gap = 0;
    int unsigned recv_stall = 0;

    // Bank number after the modulo; a count of zero forces bank 0 and a
    // count above 512 leaves the 9-bit value as it is
    function automatic logic [ROM_BANK_W-1:0] fold_rom_bank(input logic [ROM_BANK_W-1:0] b);
        logic [ROM_CNT_W-1:0] rem;
        if (rom_cnt == '0)
            return '0;
        rem = {1'b0, b} % rom_cnt;
        return rem[ROM_BANK_W-1:0];
    endfunction

    // Translate one access and apply its side effects on the bank state
    function automatic bank_map_t map_access(input bus_access_t a);
        bank_map_t  r;
        logic [7:0] rem;
        r.target = TGT_OPEN;
        r.maddr  = '0;
        if (a.action) begin
            r.target = TGT_WRITE;
            case (a.addr[15:12])
                4'h0, 4'h1: ram_on = (a.data[3:0] == 4'hA);
                4'h2: rom_bank = fold_rom_bank({rom_bank[8], a.data});
                4'h3: rom_bank = fold_rom_bank({a.data[0], rom_bank[7:0]});
                4'h4, 4'h5: begin
                    if (ram_cnt == '0) begin
                        ram_bank = '0;
                    end else begin
                        rem      = a.data % ram_cnt;
                        ram_bank = rem[RAM_BANK_W-1:0];   // counts above 16 wrap here
                    end
                end
                default: ;
            endcase
        end else begin
            case (a.addr[15:12])
                4'h0, 4'h1, 4'h2, 4'h3: begin
                    r.target = TGT_ROM;
                    r.maddr  = {7'b0, a.addr};
                end
                4'h4, 4'h5, 4'h6, 4'h7: begin
                    r.target = TGT_ROM;
                    r.maddr  = {rom_bank, a.addr[ROM_OFS_W-1:0]};
                end
                4'hA, 4'hB: begin
                    if (ram_on) begin
                        r.target = TGT_RAM;
                        r.maddr  = {6'b0, ram_bank, a.addr[RAM_OFS_W-1:0]};
                    end
                end
                default: ;
            endcase
        end
        return r;
    endfunction

    // Idle length: mostly short, now and then long, none in quiet stretches
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet)
            return 0;
        if (r < 45)
            return 0;
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Input driver: one access per transfer, payload held until taken
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_in
        bus_access_t nxt;
        if (i_in_valid && !in_xfer) begin
            // still waiting for the transfer; hold everything
        end else if (send_gap > 0) begin
            i_in_valid <= 1'b0;
            send_gap   <= send_gap - 1;
        end else if (pending_accesses.size() > 0) begin
            nxt = pending_accesses.pop_front();
            i_in_valid   <= 1'b1;
            i_action     <= nxt.action;
            i_bus_addr   <= nxt.addr;
            i_write_data <= nxt.data;
            send_gap     <= pick_gap();
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // Output back-pressure: random stalls after any cycle
    always @(negedge i_clk) begin
        if (recv_stall > 0) begin
            i_out_ready <= 1'b0;
            recv_stall  <= recv_stall - 1;
        end else begin
            i_out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                recv_stall <= pick_gap();
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on every input transfer, check every output one
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watch
        bus_access_t acc;
        bank_map_t   want;
        if (!i_rst_n) begin
            in_xfer <= 1'b0;
        end else begin
            in_xfer <= i_in_valid && o_in_ready;
            if (i_in_valid && o_in_ready) begin
                acc.action = i_action;
                acc.addr   = i_bus_addr;
                acc.data   = i_write_data;
                expected_maps.push_back(map_access(acc));
                if (i_action)
                    n_writes++;
                else
                    n_reads++;
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_maps.size() == 0) begin
                    $error("result with nothing expected: target %0d, mapped_addr 0x%06h",
                           o_target, o_mapped_addr);
                    err_cnt++;
                end else begin
                    want = expected_maps.pop_front();
                    if (o_target !== want.target) begin
                        $error("target: expected %0d, actual %0d", want.target, o_target);
                        err_cnt++;
                    end
                    if (o_mapped_addr !== want.maddr) begin
                        $error("mapped_addr: expected 0x%06h, actual 0x%06h",
                               want.maddr, o_mapped_addr);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_access(input logic act, input logic [15:0] addr,
                                input logic [7:0] data);
        bus_access_t a;
        a.action = act;
        a.addr   = addr;
        a.data   = data;
        pending_accesses.push_back(a);
    endtask

    // Mostly well-formed control writes and reads of the mapped windows,
    // the rest fully random
    task automatic queue_random_access();
        int unsigned r;
        logic [15:0] addr;
        logic [7:0]  data;
        r    = $urandom_range(0, 99);
        addr = 16'($urandom());
        data = 8'($urandom());
        if (r < 12) begin
            if ($urandom_range(0, 9) < 6)
                data[3:0] = 4'hA;
            queue_access(1'b1, {3'b000, addr[12:0]}, data);
        end else if (r < 24) begin
            queue_access(1'b1, {4'h2, addr[11:0]}, data);
        end else if (r < 30) begin
            queue_access(1'b1, {4'h3, addr[11:0]}, data);
        end else if (r < 40) begin
            queue_access(1'b1, {3'b010, addr[12:0]}, data);
        end else if (r < 50) begin
            queue_access(1'b0, {2'b00, addr[13:0]}, data);
        end else if (r < 70) begin
            queue_access(1'b0, {2'b01, addr[13:0]}, data);
        end else if (r < 85) begin
            queue_access(1'b0, {3'b101, addr[12:0]}, data);
        end else begin
            queue_access(1'($urandom()), addr, data);
        end
    endtask

    // Block until every queued access has gone in and every result is back
    task automatic wait_drained();
        @(posedge i_clk);
        #1;
        while (pending_accesses.size() != 0 || expected_maps.size() != 0 || i_in_valid) begin
            @(posedge i_clk);
            #1;
        end
    endtask

    task automatic check_reg(input logic sel, input logic [31:0] want);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {sel, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== want) begin
            $error("prdata reg %0d: expected %0d, actual %0d", sel, want, prdata);
            err_cnt++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // APB write with read-back; the model's copy changes at the write edge
    task automatic cfg_write(input logic sel, input logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (sel == REG_ROM_COUNT)
            rom_cnt = val[ROM_CNT_W-1:0];
        else
            ram_cnt = val[RAM_CNT_W-1:0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        check_reg(sel, (sel == REG_ROM_COUNT) ? {22'b0, rom_cnt} : {27'b0, ram_cnt});
    endtask

    // New bank counts, only once the mapper has gone quiet
    task automatic set_counts(input int unsigned rom_n, input int unsigned ram_n);
        wait_drained();
        repeat (14) @(posedge i_clk);   // margin only; every bank write has committed once drained
        cfg_write(REG_ROM_COUNT, rom_n);
        cfg_write(REG_RAM_COUNT, ram_n);
        n_settings++;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int unsigned rom_set[10];
        int unsigned ram_set[10];
        rom_set = '{512, 1, 0, 3, 513, 1023, 2, 0, 0, 512};
        ram_set = '{16, 1, 0, 5, 17, 31, 16, 0, 0, 16};
        rom_set[7] = $urandom_range(1, 512);
        ram_set[7] = $urandom_range(0, 16);
        rom_set[8] = $urandom_range(0, 1023);
        ram_set[8] = $urandom_range(0, 31);

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values of both counts
        check_reg(REG_ROM_COUNT, 32'd512);
        check_reg(REG_RAM_COUNT, 32'd16);

        // Small ROM count straight after reset: bank 1 stays selected
        // until the first bank write, present or not
        set_counts(2, 16);
        queue_access(1'b0, 16'h4000, 8'h00);
        queue_access(1'b0, 16'h7FFF, 8'hFF);

        // Directed pass at full size: window edges, enable/disable,
        // top banks, unmapped regions and writes that change nothing
        set_counts(512, 16);
        queue_access(1'b0, 16'h0000, 8'h00);
        queue_access(1'b0, 16'h3FFF, 8'hFF);
        queue_access(1'b0, 16'h4000, 8'h00);
        queue_access(1'b0, 16'h7FFF, 8'h00);
        queue_access(1'b0, 16'hA000, 8'h00);   // RAM still off
        queue_access(1'b1, 16'h0000, 8'h0A);
        queue_access(1'b0, 16'hA000, 8'h00);
        queue_access(1'b0, 16'hBFFF, 8'hFF);
        queue_access(1'b1, 16'h2000, 8'hFF);
        queue_access(1'b1, 16'h3000, 8'h01);   // bank 511
        queue_access(1'b0, 16'h7FFF, 8'h00);   // highest ROM offset
        queue_access(1'b1, 16'h4000, 8'hFF);   // RAM bank 15
        queue_access(1'b0, 16'hBFFF, 8'h00);
        queue_access(1'b0, 16'h8000, 8'h00);
        queue_access(1'b0, 16'h9FFF, 8'h00);
        queue_access(1'b0, 16'hC000, 8'h00);
        queue_access(1'b0, 16'hFFFF, 8'hFF);
        queue_access(1'b1, 16'h6000, 8'hFF);
        queue_access(1'b1, 16'hFFFF, 8'h00);
        queue_access(1'b1, 16'h1FFF, 8'h0B);   // RAM off again
        queue_access(1'b0, 16'hA000, 8'h00);
        queue_access(1'b1, 16'h2000, 8'h00);
        queue_access(1'b0, 16'h4000, 8'h00);   // bank 256 in the switchable window
        queue_access(1'b1, 16'h3FFF, 8'h00);

        // Random phases across extreme and random bank counts; the sender
        // holds off at every phase boundary until all results are back
        for (int k = 0; k < 10; k++) begin
            set_counts(rom_set[k], ram_set[k]);
            quiet = (k == 3 || k == 7);
            for (int n = 0; n < 105; n++)
                queue_random_access();
        end

        wait_drained();
        quiet = 1'b0;
        repeat (30) @(posedge i_clk);

        $display("Covered %0d reads and %0d writes over %0d bank-count settings.",
                 n_reads, n_writes, n_settings);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #(LIMIT_NS);
        $error("run did not complete in time");
        $display("DONE: errors detected");
        $finish;
    end

endmodule

### filelist.f
design/rrbm_pkg.sv
design/rrbm_rem_unit.sv
design/rom_ram_bank_mapper_core.sv
tb/tb_top.sv
